/* src/dcrt_pkg.sv */
// Shared constants and types for the duty-cycle receive timer.
package dcrt_pkg;

  localparam logic [3:0]  PRESCALE_LIMIT = 4'd10;
  localparam logic [15:0] BASE_UNIT      = 16'd1;
  localparam logic [7:0]  LEVEL_RESET    = 8'hff;

  localparam logic [1:0] CMD_NONE = 2'd0;
  localparam logic [1:0] CMD_IDLE = 2'd1;
  localparam logic [1:0] CMD_RXON = 2'd2;

  typedef struct packed {
    logic [1:0] cmd;
    logic       rx_on;
  } res_t;

endpackage

/* src/dcrt_core.sv */
// Timer state and per-tick update logic of the duty-cycle receive timer.
module dcrt_core import dcrt_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic [7:0] cfg_level,
  input  logic       tick,
  input  logic       sleep,
  output res_t       res
);

  logic [7:0]  level_r;
  logic [3:0]  prescale_r,  prescale_nxt;
  logic [7:0]  last_level_r, last_level_nxt;
  logic [15:0] work_limit_r, work_limit_nxt;
  logic [15:0] idle_limit_r, idle_limit_nxt;
  logic [15:0] work_ticks_r, work_ticks_nxt;
  logic [15:0] idle_ticks_r, idle_ticks_nxt;
  logic        rx_active_r,  rx_active_nxt;
  logic        acting;
  logic [15:0] work_inc, idle_inc;
  logic [1:0]  cmd;

  assign acting   = prescale_r > PRESCALE_LIMIT;
  assign work_inc = work_ticks_r + 16'd1;
  assign idle_inc = idle_ticks_r + 16'd1;

  always_comb begin
    prescale_nxt   = prescale_r + 4'd1;
    last_level_nxt = last_level_r;
    work_limit_nxt = work_limit_r;
    idle_limit_nxt = idle_limit_r;
    work_ticks_nxt = work_ticks_r;
    idle_ticks_nxt = idle_ticks_r;
    rx_active_nxt  = rx_active_r;
    cmd            = CMD_NONE;
    if (acting) begin
      prescale_nxt = 4'd0;
      if (last_level_r != level_r) begin
        last_level_nxt = level_r;
        if (level_r inside {[8'd0:8'd3]}) begin
          work_limit_nxt = BASE_UNIT;
          idle_limit_nxt = BASE_UNIT << level_r[1:0];
        end
      end
      if (sleep) begin
        if (work_ticks_r < work_limit_nxt) begin
          work_ticks_nxt = work_inc;
          if (work_inc == work_limit_nxt) begin
            cmd           = CMD_IDLE;
            rx_active_nxt = 1'b0;
          end
        end else if (idle_ticks_r < idle_limit_nxt) begin
          idle_ticks_nxt = idle_inc;
          if (idle_inc == idle_limit_nxt) begin
            cmd            = CMD_RXON;
            rx_active_nxt  = 1'b1;
            idle_ticks_nxt = 16'd0;
            work_ticks_nxt = 16'd0;
          end
        end
      end else if (!rx_active_r) begin
        cmd           = CMD_RXON;
        rx_active_nxt = 1'b1;
      end
    end
  end

  assign res.cmd   = cmd;
  assign res.rx_on = rx_active_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      level_r      <= 8'd0;
      prescale_r   <= 4'd0;
      last_level_r <= LEVEL_RESET;
      work_limit_r <= 16'd0;
      idle_limit_r <= 16'd0;
      work_ticks_r <= 16'd0;
      idle_ticks_r <= 16'd0;
      rx_active_r  <= 1'b0;
    end else begin
      if (cfg_we) begin
        level_r <= cfg_level;
      end
      if (tick) begin
        prescale_r   <= prescale_nxt;
        last_level_r <= last_level_nxt;
        work_limit_r <= work_limit_nxt;
        idle_limit_r <= idle_limit_nxt;
        work_ticks_r <= work_ticks_nxt;
        idle_ticks_r <= idle_ticks_nxt;
        rx_active_r  <= rx_active_nxt;
      end
    end
  end

  a_idle_turns_off: assert property (@(posedge clk) disable iff (!rst_n)
    (tick && res.cmd == CMD_IDLE) |=> !rx_active_r)
    else $error("go idle did not clear receiver state");

  a_cmd_only_acting: assert property (@(posedge clk) disable iff (!rst_n)
    (res.cmd != CMD_NONE) |-> acting)
    else $error("command on non-acting tick");

  a_prescale_wraps: assert property (@(posedge clk) disable iff (!rst_n)
    (tick && acting) |=> (prescale_r == 4'd0))
    else $error("prescaler not cleared on acting tick");

endmodule

/* src/duty_cycle_receive_timer_top.sv */
// Top level of the duty-cycle receive timer: stream ports, result register and skid.
// An accepted tick's result word is registered for out_, or in the skid while out stalls.
// One tick word per cycle while skid is empty; timer state updates in a single pass on accept.
// A two-entry output stage (result register plus skid) takes one more word once out stalls.
// Reset (rst_n low, synchronous): counters, limits and receiver state cleared, last level 255.
// Save level resets to 0; no result words are held after reset.
module duty_cycle_receive_timer_top import dcrt_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [0] sleep_enable, [7:1] zero
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [1:0] radio_command, [2] receiver_on, [7:3] zero
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [7:0] cfg_data    // power_save_level
);

  res_t res;
  res_t out_res_r, skid_res_r;
  logic out_valid_r, skid_valid_r;
  logic accept;

  assign in_tready = !skid_valid_r;
  assign cfg_ready = 1'b1;
  assign accept    = in_tvalid && in_tready;

  dcrt_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_valid),
    .cfg_level (cfg_data),
    .tick      (accept),
    .sleep     (in_tdata[0]),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      if (!out_valid_r || out_tready) begin
        if (skid_valid_r) begin
          out_valid_r  <= 1'b1;
          skid_valid_r <= 1'b0;
        end else begin
          out_valid_r <= accept;
        end
      end else if (accept) begin
        skid_valid_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid_r || out_tready) begin
      out_res_r <= skid_valid_r ? skid_res_r : res;
    end else if (accept) begin
      skid_res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'd0, out_res_r.rx_on, out_res_r.cmd};

  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid holds a word while result register is empty");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_tready) |=> (out_valid_r && $stable(out_res_r)))
    else $error("stalled result word changed");

  a_skid_drains: assert property (@(posedge clk) disable iff (!rst_n)
    (skid_valid_r && out_tready) |=> !skid_valid_r)
    else $error("skid word not moved on");

endmodule

/* sim/tb_top.sv */
// Self-checking testbench for the duty-cycle receive timer: random ticks, levels and stalls.
module tb_top import dcrt_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  class timer_scoreboard;
    logic [7:0]  save_level;
    logic [3:0]  prescale;
    logic [7:0]  loaded_level;
    logic [15:0] work_limit;
    logic [15:0] idle_limit;
    logic [15:0] work_ticks;
    logic [15:0] idle_ticks;
    logic        rx_active;
    res_t        pending_results[$];
    int          failures;

    function new();
      save_level   = '0;
      prescale     = '0;
      loaded_level = LEVEL_RESET;
      work_limit   = '0;
      idle_limit   = '0;
      work_ticks   = '0;
      idle_ticks   = '0;
      rx_active    = 1'b0;
      failures     = 0;
    endfunction

    function void set_level(logic [7:0] lvl);
      save_level = lvl;
    endfunction

    // Advance the timer by one tick and queue the word it should produce.
    function void note_tick(logic sleep);
      res_t r;
      int   mult;
      r.cmd = CMD_NONE;
      if (prescale > PRESCALE_LIMIT) begin
        prescale = '0;
        if (loaded_level != save_level) begin
          loaded_level = save_level;
          // levels above three leave the thresholds alone
          if (save_level < 8'd4) begin
            mult       = 1 << save_level;
            work_limit = BASE_UNIT;
            idle_limit = 16'(mult * BASE_UNIT);
          end
        end
        if (sleep) begin
          if (work_ticks < work_limit) begin
            work_ticks = work_ticks + 16'd1;
            if (work_ticks == work_limit) begin
              r.cmd     = CMD_IDLE;
              rx_active = 1'b0;
            end
          end else if (idle_ticks < idle_limit) begin
            idle_ticks = idle_ticks + 16'd1;
            if (idle_ticks == idle_limit) begin
              r.cmd      = CMD_RXON;
              rx_active  = 1'b1;
              idle_ticks = '0;
              work_ticks = '0;
            end
          end
        end else if (!rx_active) begin
          r.cmd     = CMD_RXON;
          rx_active = 1'b1;
        end
      end else begin
        prescale = prescale + 4'd1;
      end
      r.rx_on = rx_active;
      pending_results.push_back(r);
    endfunction

    function void check_word(logic [7:0] word);
      res_t want;
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result word, expected none, got %h", $time, word);
        failures++;
        return;
      end
      want = pending_results.pop_front();
      if (word[1:0] !== want.cmd) begin
        $display("%0t: radio_command expected %0d got %0d", $time, want.cmd, word[1:0]);
        failures++;
      end
      if (word[2] !== want.rx_on) begin
        $display("%0t: receiver_on expected %0d got %0d", $time, want.rx_on, word[2]);
        failures++;
      end
    endfunction
  endclass

  logic       clk;
  logic       rst_n;
  logic       in_tvalid;
  logic       in_tready;
  logic [7:0] in_tdata;
  logic       out_tvalid;
  logic       out_tready;
  logic [7:0] out_tdata;
  logic       cfg_valid;
  logic       cfg_ready;
  logic [7:0] cfg_data;
  bit         quiet;

  timer_scoreboard board = new();
  logic [7:0] level_plan [8] = '{8'd3, 8'd0, 8'd1, 8'd255, 8'd2, 8'd200, 8'd0, 8'd3};

  duty_cycle_receive_timer_top DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #(5_000_000);
    $display("Test completed with failures");
    $finish;
  end

  task automatic send_tick(input logic sleep);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 6);
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {7'b0, sleep};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    board.note_tick(sleep);
  endtask

  // hold off input until every outstanding word has come back
  task automatic drain();
    in_tvalid <= 1'b0;
    while (board.pending_results.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_level(input logic [7:0] lvl);
    drain();
    cfg_valid <= 1'b1;
    cfg_data  <= lvl;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    board.set_level(lvl);
  endtask

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) board.check_word(out_tdata);
  end

  initial begin
    int stall;
    out_tready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      stall = quiet ? 0 : $urandom_range(0, 6);
      if (stall != 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
      while (!out_tvalid) @(posedge clk);
    end
  end

  initial begin
    int         total;
    int         phase;
    int         span;
    int         pause_at;
    int         sleep_mode;
    logic       sleep;
    logic [7:0] lvl;
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    cfg_valid <= 1'b0;
    cfg_data  <= '0;
    quiet     = 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // level matching the reset value: thresholds stay zero, sleep gives no command
    write_level(8'hff);
    repeat (12) send_tick(1'b1);
    // sleep off with receiver off: receiver on
    repeat (12) send_tick(1'b0);

    total = 24;
    phase = 0;
    while (total < 1950) begin
      if (phase < 8) lvl = level_plan[phase];
      else if ($urandom_range(0, 3) == 0) lvl = 8'($urandom_range(4, 255));
      else lvl = 8'($urandom_range(0, 3));
      write_level(lvl);
      quiet      = ($urandom_range(0, 3) == 0);
      sleep_mode = $urandom_range(0, 4);
      span       = $urandom_range(100, 220);
      pause_at   = $urandom_range(10, span - 1);
      for (int i = 0; i < span; i++) begin
        if (phase == 2 && i == pause_at) drain();
        if (sleep_mode == 0) sleep = 1'($urandom_range(0, 1));
        else sleep = ($urandom_range(0, 15) != 0);
        send_tick(sleep);
      end
      total += span;
      phase++;
    end

    quiet = 1'b0;
    drain();
    repeat (4) @(posedge clk);
    if (board.failures == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule
